### sv/lcfs_pkg.sv
// ----------------------------------------------------------------------------
// lcfs_pkg
// Shared constants and types of the LED cube frame scanner.
// ----------------------------------------------------------------------------
package lcfs_pkg;

   // Build-time default for the longest chain
   localparam int MAX_CUBES_DEF = 25;

   // Field widths
   localparam int COUNT_W    = 5;
   localparam int CODE_W     = 8;
   localparam int WORD_W     = 16;
   localparam int FRAME_W    = CODE_W + WORD_W;
   localparam int MODE_W     = 2;
   localparam int COORD_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LAYER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_VOXEL = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CUBE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER0     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER1     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER2     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAYER3     = 3'd4;

   // Register reset values
   localparam logic [COUNT_W-1:0] CUBE_COUNT_RST = 5'd1;
   localparam logic [CODE_W-1:0]  LAYER0_RST     = 8'd1;
   localparam logic [CODE_W-1:0]  LAYER1_RST     = 8'd2;
   localparam logic [CODE_W-1:0]  LAYER2_RST     = 8'd4;
   localparam logic [CODE_W-1:0]  LAYER3_RST     = 8'd8;

   // Control strobes from the sequencer to the frame store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

### sv/led_cube_frame_scanner_unit.sv
// ----------------------------------------------------------------------------
// led_cube_frame_scanner_unit
// Frame store and refresh scanner for a daisy chain of 4x4x4 LED cubes.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+-------------------------
//  request   | req_mode .. req_led_on                   | start high, busy low
//  response  | rsp_frame_word, rsp_latch_after, rsp_last| rsp_valid, one cycle
//  csr       | csr_index, csr_wdata                     | csr_we, no wait
//
//  Scan tick: one store read, then one triplet a cycle from the triplet counter
//  and compare. Layer write: a single store write. Voxel write: read, then
//  modify and write. Clear all: the accept cycle and then one store word a
//  cycle through the write port, for all MAX_CUBES*4 store words.
//  Reset: synchronous; the store reads as zero through its valid bits at once,
//  so no clearing pass follows reset.
//  Stalls: none on the response side; the receiver takes each triplet in the
//  cycle it is shown. busy stays high while a request is being worked on.
// ----------------------------------------------------------------------------
module led_cube_frame_scanner_unit #(
   parameter int MAX_CUBES = lcfs_pkg::MAX_CUBES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              start,
   output logic                              busy,
   input  logic [lcfs_pkg::MODE_W-1:0]       req_mode,
   input  logic [lcfs_pkg::COUNT_W-1:0]      req_cube_index,
   input  logic [lcfs_pkg::COORD_W-1:0]      req_layer_index,
   input  logic [lcfs_pkg::COORD_W-1:0]      req_x_pos,
   input  logic [lcfs_pkg::COORD_W-1:0]      req_y_pos,
   input  logic [lcfs_pkg::WORD_W-1:0]       req_layer_bits,
   input  logic                              req_led_on,
   // response
   output logic                              rsp_valid,
   output logic [lcfs_pkg::FRAME_W-1:0]      rsp_frame_word,
   output logic                              rsp_latch_after,
   output logic                              rsp_last,
   // configuration
   input  logic                              csr_we,
   input  logic [lcfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lcfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH  = MAX_CUBES * 4;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = (ADDR_W > lcfs_pkg::COUNT_W + 2) ? ADDR_W : lcfs_pkg::COUNT_W + 2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EMIT  = 4'b0010,
      ST_VOXEL = 4'b0100,
      ST_CLEAR = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [lcfs_pkg::COUNT_W-1:0] cube_count_ff, cube_count_in;
   logic [lcfs_pkg::CODE_W-1:0]  layer_code_ff [4];
   logic [lcfs_pkg::CODE_W-1:0]  layer_code_in [4];
   logic [lcfs_pkg::COUNT_W-1:0] csr_count;

   // scan state
   logic [ADDR_W-1:0]            pos_ff, pos_in;
   logic [ADDR_W-1:0]            cur_pos_ff, cur_pos_in;
   logic [lcfs_pkg::COUNT_W-1:0] cube_sel_ff, cube_sel_in;
   logic [lcfs_pkg::COUNT_W-1:0] k_ff, k_in;

   // voxel and clear state
   logic [ADDR_W-1:0]            vox_addr_ff, vox_addr_in;
   logic [lcfs_pkg::WORD_W-1:0]  vox_mask_ff, vox_mask_in;
   logic                         vox_on_ff, vox_on_in;
   logic [ADDR_W-1:0]            clr_ff, clr_in;

   // response registers
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lcfs_pkg::FRAME_W-1:0] rsp_word_ff, rsp_word_in;
   logic                         rsp_latch_ff, rsp_latch_in;
   logic                         rsp_last_ff, rsp_last_in;

   // store port
   lcfs_pkg::store_ctl_type      st_ctl;
   logic [ADDR_W-1:0]            st_wr_addr;
   logic [lcfs_pkg::WORD_W-1:0]  st_wr_data;
   logic [ADDR_W-1:0]            st_rd_addr;
   logic [lcfs_pkg::WORD_W-1:0]  st_rd_data;

   // helpers
   logic                         accept;
   logic [CMP_W-1:0]             count_x4;
   logic [ADDR_W-1:0]            pos_eff;
   logic [CMP_W-1:0]             pos_next;
   logic                         cube_ok;
   logic [ADDR_W-1:0]            req_addr;
   logic [lcfs_pkg::WORD_W-1:0]  req_mask;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign count_x4 = CMP_W'({cube_count_ff, 2'b00});
   // restart the scan if the count has shrunk beneath the position
   assign pos_eff  = (CMP_W'(pos_ff) >= count_x4) ? '0 : pos_ff;
   assign pos_next = CMP_W'(cur_pos_ff) + CMP_W'(1);
   assign cube_ok  = (req_cube_index < cube_count_ff);
   assign req_addr = ADDR_W'({req_cube_index, req_layer_index});
   assign req_mask = lcfs_pkg::WORD_W'(1) << {req_y_pos, req_x_pos};

   // cube count: only the low five bits count; zero reads as one, values above MAX_CUBES saturate
   always_comb begin
      csr_count = csr_wdata[lcfs_pkg::COUNT_W-1:0];
      if (csr_count == '0) begin
         csr_count = lcfs_pkg::COUNT_W'(1);
      end else if (int'(csr_count) > MAX_CUBES) begin
         csr_count = lcfs_pkg::COUNT_W'(MAX_CUBES);
      end
   end

   always_comb begin
      cube_count_in = cube_count_ff;
      layer_code_in = layer_code_ff;
      if (csr_we) begin
         unique case (csr_index)
            lcfs_pkg::REG_CUBE_COUNT: cube_count_in    = csr_count;
            lcfs_pkg::REG_LAYER0:     layer_code_in[0] = csr_wdata;
            lcfs_pkg::REG_LAYER1:     layer_code_in[1] = csr_wdata;
            lcfs_pkg::REG_LAYER2:     layer_code_in[2] = csr_wdata;
            lcfs_pkg::REG_LAYER3:     layer_code_in[3] = csr_wdata;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cur_pos_in   = cur_pos_ff;
      cube_sel_in  = cube_sel_ff;
      k_in         = k_ff;
      vox_addr_in  = vox_addr_ff;
      vox_mask_in  = vox_mask_ff;
      vox_on_in    = vox_on_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      rsp_latch_in = rsp_latch_ff;
      rsp_last_in  = rsp_last_ff;
      st_ctl       = '0;
      st_wr_addr   = req_addr;
      st_wr_data   = req_layer_bits;
      st_rd_addr   = pos_eff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  lcfs_pkg::MODE_SCAN: begin
                     // fetch the layer word, then count out the triplets
                     st_ctl.rd_en = 1'b1;
                     cur_pos_in   = pos_eff;
                     cube_sel_in  = lcfs_pkg::COUNT_W'(pos_eff >> 2);
                     k_in         = '0;
                     state_in     = ST_EMIT;
                  end
                  lcfs_pkg::MODE_LAYER: begin
                     st_ctl.wr_en = cube_ok;
                  end
                  lcfs_pkg::MODE_VOXEL: begin
                     if (cube_ok) begin
                        st_ctl.rd_en = 1'b1;
                        st_rd_addr   = req_addr;
                        vox_addr_in  = req_addr;
                        vox_mask_in  = req_mask;
                        vox_on_in    = req_led_on;
                        state_in     = ST_VOXEL;
                     end
                  end
                  lcfs_pkg::MODE_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end

         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = (k_ff == '0) ?
                           {layer_code_ff[cur_pos_ff[1:0]], st_rd_data} : '0;
            rsp_latch_in = (k_ff == cube_sel_ff);
            rsp_last_in  = (k_ff == cube_count_ff);
            k_in         = k_ff + lcfs_pkg::COUNT_W'(1);
            if (k_ff == cube_count_ff) begin
               // advance the scan position and wrap at the end of the chain
               pos_in   = (pos_next >= count_x4) ? '0 : ADDR_W'(pos_next);
               state_in = ST_IDLE;
            end
         end

         ST_VOXEL: begin
            st_ctl.wr_en = 1'b1;
            st_wr_addr   = vox_addr_ff;
            st_wr_data   = vox_on_ff ? (st_rd_data | vox_mask_ff)
                                     : (st_rd_data & ~vox_mask_ff);
            state_in     = ST_IDLE;
         end

         ST_CLEAR: begin
            st_ctl.wr_en = 1'b1;
            st_wr_addr   = clr_ff;
            st_wr_data   = '0;
            clr_in       = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         cube_count_ff <= lcfs_pkg::CUBE_COUNT_RST;
         layer_code_ff <= '{lcfs_pkg::LAYER0_RST, lcfs_pkg::LAYER1_RST,
                            lcfs_pkg::LAYER2_RST, lcfs_pkg::LAYER3_RST};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         cube_count_ff <= cube_count_in;
         layer_code_ff <= layer_code_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_pos_ff   <= cur_pos_in;
      cube_sel_ff  <= cube_sel_in;
      k_ff         <= k_in;
      vox_addr_ff  <= vox_addr_in;
      vox_mask_ff  <= vox_mask_in;
      vox_on_ff    <= vox_on_in;
      clr_ff       <= clr_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_latch_ff <= rsp_latch_in;
      rsp_last_ff  <= rsp_last_in;
   end

   lcfs_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_word  = rsp_word_ff;
   assign rsp_latch_after = rsp_latch_ff;
   assign rsp_last        = rsp_last_ff;

   // the final triplet leaves the sequencer free
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final triplet shown while still busy");

   // the latch always falls on a triplet before the final one
   a_latch_not_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_latch_after && rsp_last))
      else $error("latch and final mark on the same triplet");

   // the triplet counter never runs past the chain
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (k_ff <= cube_count_ff))
      else $error("triplet counter beyond cube count");

   // a scan reads a position inside the chain
   a_pos_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (CMP_W'(cur_pos_ff) < count_x4))
      else $error("scan position outside the chain");

endmodule

### sv/lcfs_store.sv
// ----------------------------------------------------------------------------
// lcfs_store
// Frame store: one layer word per cube and layer, registered read, valid bits.
// ----------------------------------------------------------------------------
module lcfs_store #(
   parameter int DEPTH = lcfs_pkg::MAX_CUBES_DEF * 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcfs_pkg::store_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [lcfs_pkg::WORD_W-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [lcfs_pkg::WORD_W-1:0]   rd_data
);

   logic [lcfs_pkg::WORD_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]            valid_ff;
   logic [DEPTH-1:0]            valid_in;
   logic [lcfs_pkg::WORD_W-1:0] rdata_ff;
   logic                        rvalid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   // A word never written since reset reads as zero
   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule
